@@ src/bfea_pkg.sv @@
package bfea_pkg;

	localparam int unsigned DEFAULT_MAX_EXTENTS = 64;
	localparam logic [31:0] REGION_RESET = 32'd131072;
	localparam logic [7:0]  HEADER_RESET = 8'd8;

	typedef enum logic [1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_SEED    = 2'd2,
		KIND_CLEAR   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		CFG_REGION = 1'b0,
		CFG_HEADER = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_UPDATE,
		S_SUM,
		S_SUM_END,
		S_DONE
	} state_t;

	function automatic logic [31:0] sat32(input logic [33:0] v);
		return (|v[33:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

@@ src/best_fit_extent_allocator_core.sv @@
// Best-fit free extent allocator with coalescing.
// Input stream (s_*): one command per transaction. s_tuser[1:0] is the kind
// (allocate, release, seed, clear); s_tdata holds offset and byte count.
// Output stream (m_*): exactly one result per command: status, granted
// offset, largest free payload and the number of free extents.
// Config channel (cfg_*): always ready; index 0 region size, 1 header size.
// Write it only while no command is in flight.
// One pass over the extent memory, one port read per cycle, finds the
// fit or neighbours; the update state writes the change back; a second
// pass over the memory collects the largest extent and the count.
// One command is handled at a time; s_tready is high only when idle.
// Reset empties the table (valid bits cleared) and loads the register
// defaults. A stalled m_tready holds the result; the next command may be
// accepted and run, and its result waits until the output register frees.
module best_fit_extent_allocator_core
	import bfea_pkg::*;
#(
	parameter int unsigned MAX_EXTENTS = DEFAULT_MAX_EXTENTS,
	localparam int unsigned IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1,
	localparam int unsigned CNT_W = $clog2(MAX_EXTENTS + 1),
	localparam int unsigned OUT_W = ((66 + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,   // extent_offset, extent_bytes
	input  logic [1:0]       s_tuser,   // kind
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // status, alloc_offset, largest_payload, extent_count
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_EXTENTS - 1);

	state_t state_q, state_d;

	logic [31:0] region_q;
	logic [7:0]  hdr_q;

	kind_t       kind_q;
	logic [31:0] off_q, bytes_q;

	logic [MAX_EXTENTS-1:0] valid_q, eq_q;
	logic [IDX_W-1:0]       idx_q;

	logic [31:0] start_mem [MAX_EXTENTS];
	logic [31:0] len_mem   [MAX_EXTENTS];

	logic             rd_v_s1, rd_sum_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [31:0]      rd_start_s1, rd_len_s1;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_start, wr_len;

	logic             best_f_q, p_f_q, n_f_q, s_f_q, free_f_q;
	logic [IDX_W-1:0] best_i_q, p_i_q, n_i_q, s_i_q, free_i_q;
	logic [31:0]      best_start_q, best_len_q, p_start_q, p_len_q, n_start_q, n_len_q;

	logic [31:0]      max_q;
	logic [CNT_W-1:0] cnt_q;

	status_t     status_q, status_d;
	logic [31:0] aoff_q, aoff_d;

	logic              out_v_q;
	logic [OUT_W-1:0]  out_q;

	logic [32:0] need;
	logic        pm, nm;
	logic [33:0] merged;
	logic [MAX_EXTENTS-1:0] valid_upd;
	logic [31:0] largest_pl;
	logic        accept, rd_issue, entry_v;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_q;

	assign need    = {1'b0, bytes_q} + {25'b0, hdr_q};
	assign pm      = p_f_q && ({1'b0, p_start_q} + {1'b0, p_len_q}) == {1'b0, off_q};
	assign nm      = n_f_q && ({2'b0, off_q} + {1'b0, need}) == {2'b0, n_start_q};
	assign merged  = {2'b0, p_len_q} + {1'b0, need} + (nm ? {2'b0, n_len_q} : 34'd0);
	assign entry_v = valid_q[rd_idx_s1];
	assign largest_pl = (max_q > {24'b0, hdr_q}) ? max_q - {24'b0, hdr_q} : 32'd0;
	assign rd_issue = (state_q == S_SCAN) || (state_q == S_SUM);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (accept) state_d = S_SCAN;
			S_SCAN:     if (idx_q == LAST_IDX) state_d = S_SCAN_END;
			S_SCAN_END: state_d = S_UPDATE;
			S_UPDATE:   state_d = S_SUM;
			S_SUM:      if (idx_q == LAST_IDX) state_d = S_SUM_END;
			S_SUM_END:  state_d = S_DONE;
			S_DONE:     if (!out_v_q || m_tready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_start  = off_q;
		wr_len    = bytes_q;
		valid_upd = valid_q;
		status_d  = ST_OK;
		aoff_d    = 32'd0;
		case (kind_q)
			KIND_ALLOC: begin
				if (need[32] || !best_f_q) begin
					status_d = ST_NOFIT;
					aoff_d   = 32'hFFFF_FFFF;
				end else begin
					aoff_d = best_start_q;
					if ({1'b0, best_len_q} > need) begin
						wr_en    = 1'b1;
						wr_addr  = best_i_q;
						wr_start = best_start_q + need[31:0];
						wr_len   = best_len_q - need[31:0];
					end else begin
						valid_upd[best_i_q] = 1'b0;
					end
				end
			end
			KIND_RELEASE: begin
				if (pm) begin
					wr_en    = 1'b1;
					wr_addr  = p_i_q;
					wr_start = p_start_q;
					wr_len   = sat32(merged);
					if (nm) valid_upd[n_i_q] = 1'b0;
				end else if (nm) begin
					wr_en     = 1'b1;
					wr_addr   = n_i_q;
					wr_start  = off_q;
					wr_len    = sat32({2'b0, n_len_q} + {1'b0, need});
					valid_upd = valid_q & ~eq_q;
				end else if (s_f_q) begin
					wr_en   = 1'b1;
					wr_addr = s_i_q;
					wr_len  = sat32({1'b0, need});
				end else if (free_f_q) begin
					wr_en   = 1'b1;
					wr_addr = free_i_q;
					wr_len  = sat32({1'b0, need});
					valid_upd[free_i_q] = 1'b1;
				end else begin
					status_d = ST_FULL;
				end
			end
			KIND_SEED: begin
				if (!s_f_q) begin
					if (free_f_q) begin
						wr_en   = 1'b1;
						wr_addr = free_i_q;
						valid_upd[free_i_q] = 1'b1;
					end else begin
						status_d = ST_FULL;
					end
				end
			end
			KIND_CLEAR: begin
				wr_en     = 1'b1;
				wr_addr   = '0;
				wr_start  = 32'd0;
				wr_len    = region_q;
				valid_upd = '0;
				valid_upd[0] = 1'b1;
			end
			default: ;
		endcase
		if (state_q != S_UPDATE) begin
			wr_en     = 1'b0;
			valid_upd = valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[wr_addr] <= wr_start;
			len_mem[wr_addr]   <= wr_len;
		end
		rd_start_s1 <= start_mem[idx_q];
		rd_len_s1   <= len_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			region_q  <= REGION_RESET;
			hdr_q     <= HEADER_RESET;
			valid_q   <= '0;
			idx_q     <= '0;
			rd_v_s1   <= 1'b0;
			rd_sum_s1 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_REGION: region_q <= cfg_data;
					CFG_HEADER: hdr_q    <= cfg_data[7:0];
					default: ;
				endcase
			end
			valid_q   <= valid_upd;
			rd_v_s1   <= rd_issue;
			rd_sum_s1 <= (state_q == S_SUM);
			if (rd_issue && idx_q != LAST_IDX) idx_q <= idx_q + 1'b1;
			else idx_q <= '0;
			if (state_q == S_DONE && (!out_v_q || m_tready)) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (accept) begin
			kind_q   <= kind_t'(s_tuser);
			off_q    <= s_tdata[31:0];
			bytes_q  <= s_tdata[63:32];
			best_f_q <= 1'b0;
			p_f_q    <= 1'b0;
			n_f_q    <= 1'b0;
			s_f_q    <= 1'b0;
			free_f_q <= 1'b0;
			eq_q     <= '0;
		end else if (rd_v_s1 && !rd_sum_s1) begin
			if (entry_v) begin
				if ({1'b0, rd_len_s1} >= need && (!best_f_q || rd_len_s1 < best_len_q ||
				    (rd_len_s1 == best_len_q && rd_start_s1 < best_start_q))) begin
					best_f_q     <= 1'b1;
					best_i_q     <= rd_idx_s1;
					best_start_q <= rd_start_s1;
					best_len_q   <= rd_len_s1;
				end
				if (rd_start_s1 <= off_q) begin
					if (!p_f_q || rd_start_s1 > p_start_q) begin
						p_f_q     <= 1'b1;
						p_i_q     <= rd_idx_s1;
						p_start_q <= rd_start_s1;
						p_len_q   <= rd_len_s1;
					end
				end else if (!n_f_q || rd_start_s1 < n_start_q) begin
					n_f_q     <= 1'b1;
					n_i_q     <= rd_idx_s1;
					n_start_q <= rd_start_s1;
					n_len_q   <= rd_len_s1;
				end
				if (rd_start_s1 == off_q) begin
					eq_q[rd_idx_s1] <= 1'b1;
					if (!s_f_q) begin
						s_f_q <= 1'b1;
						s_i_q <= rd_idx_s1;
					end
				end
			end else if (!free_f_q) begin
				free_f_q <= 1'b1;
				free_i_q <= rd_idx_s1;
			end
		end
		if (state_q == S_UPDATE) begin
			status_q <= status_d;
			aoff_q   <= aoff_d;
			max_q    <= 32'd0;
			cnt_q    <= '0;
		end else if (rd_v_s1 && rd_sum_s1 && entry_v) begin
			cnt_q <= cnt_q + 1'b1;
			if (rd_len_s1 > max_q) max_q <= rd_len_s1;
		end
		if (state_q == S_DONE && (!out_v_q || m_tready)) begin
			out_q <= {(OUT_W - 66 - CNT_W)'(0), cnt_q, largest_pl, aoff_q, status_q};
		end
	end

	a_nofit_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == ST_NOFIT |-> m_tdata[33:2] == 32'hFFFF_FFFF)
		else $error("nofit result without all-ones offset");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[65+CNT_W:66] <= CNT_W'(MAX_EXTENTS))
		else $error("extent count above table size");

	a_update_then_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPDATE |=> state_q == S_SUM && idx_q == '0)
		else $error("update not followed by summary pass");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_SCAN && !s_tready)
		else $error("accepted command did not start scan");

endmodule

@@ tb/sv/bfea_checker.sv @@
module bfea_checker
	import bfea_pkg::*;
#(
	parameter int unsigned NUM_EXT = DEFAULT_MAX_EXTENTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,    // extent_offset, extent_bytes
	input  logic [1:0]  s_tuser,    // kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,    // status, alloc_offset, largest_payload, extent_count
	output int          fail_count,
	output int          pending,
	output int          nofit_seen,
	output int          full_seen
);

	typedef struct packed {
		status_t     status;
		logic [31:0] alloc_offset;
		logic [31:0] largest_payload;
		logic [6:0]  extent_count;
	} alloc_result_t;

	logic [31:0] region_sz;
	logic [7:0]  hdr_sz;
	logic [31:0] ext_start [NUM_EXT];
	logic [31:0] ext_len   [NUM_EXT];
	logic        ext_used  [NUM_EXT];
	alloc_result_t expected_results [8];
	logic [2:0]  exp_wr, exp_rd;

	function automatic logic [31:0] clamp32(input logic [33:0] v);
		return (|v[33:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic int lowest_free();
		for (int i = 0; i < NUM_EXT; i++)
			if (!ext_used[i])
				return i;
		return -1;
	endfunction

	function automatic int slot_at(input logic [31:0] s);
		for (int i = 0; i < NUM_EXT; i++)
			if (ext_used[i] && ext_start[i] == s)
				return i;
		return -1;
	endfunction

	task automatic predict_command(input kind_t k, input logic [31:0] off,
			input logic [31:0] bytes, output alloc_result_t r);
		logic [32:0] need;
		logic [33:0] len;
		logic [31:0] big;
		int best, p, n, s, cnt;
		bit pm, nm;
		r = '0;
		r.status = ST_OK;
		need = {1'b0, bytes} + {25'd0, hdr_sz};
		case (k)
			KIND_ALLOC: begin
				best = -1;
				if (need[32]) begin
					r.status = ST_NOFIT;
				end else begin
					for (int i = 0; i < NUM_EXT; i++) begin
						if (!ext_used[i] || ext_len[i] < need[31:0])
							continue;
						if (best < 0 || ext_len[i] < ext_len[best] ||
								(ext_len[i] == ext_len[best] &&
								ext_start[i] < ext_start[best]))
							best = i;
					end
					if (best < 0)
						r.status = ST_NOFIT;
				end
				if (r.status == ST_NOFIT) begin
					r.alloc_offset = 32'hFFFF_FFFF;
				end else begin
					r.alloc_offset = ext_start[best];
					if (ext_len[best] > need[31:0]) begin
						ext_start[best] = ext_start[best] + need[31:0];
						ext_len[best] = ext_len[best] - need[31:0];
					end else begin
						ext_used[best] = 1'b0;
					end
				end
			end
			KIND_RELEASE: begin
				p = -1;
				n = -1;
				for (int i = 0; i < NUM_EXT; i++) begin
					if (!ext_used[i])
						continue;
					if (ext_start[i] <= off) begin
						if (p < 0 || ext_start[i] > ext_start[p])
							p = i;
					end else if (n < 0 || ext_start[i] < ext_start[n]) begin
						n = i;
					end
				end
				pm = p >= 0 && ({1'b0, ext_start[p]} + {1'b0, ext_len[p]}) == {1'b0, off};
				nm = n >= 0 && ({1'b0, off} + need) == {1'b0, ext_start[n]};
				if (pm) begin
					len = {2'b0, ext_len[p]} + {1'b0, need};
					if (nm) begin
						len = len + {2'b0, ext_len[n]};
						ext_used[n] = 1'b0;
					end
					ext_len[p] = clamp32(len);
				end else if (nm) begin
					ext_len[n] = clamp32({2'b0, ext_len[n]} + {1'b0, need});
					ext_start[n] = off;
					for (int i = 0; i < NUM_EXT; i++)
						if (i != n && ext_used[i] && ext_start[i] == off)
							ext_used[i] = 1'b0;
				end else begin
					s = slot_at(off);
					if (s < 0) begin
						s = lowest_free();
						if (s >= 0) begin
							ext_used[s] = 1'b1;
							ext_start[s] = off;
						end
					end
					if (s < 0)
						r.status = ST_FULL;
					else
						ext_len[s] = clamp32({1'b0, need});
				end
			end
			KIND_SEED: begin
				if (slot_at(off) < 0) begin
					s = lowest_free();
					if (s < 0) begin
						r.status = ST_FULL;
					end else begin
						ext_used[s] = 1'b1;
						ext_start[s] = off;
						ext_len[s] = bytes;
					end
				end
			end
			default: begin
				for (int i = 0; i < NUM_EXT; i++)
					ext_used[i] = 1'b0;
				ext_used[0] = 1'b1;
				ext_start[0] = '0;
				ext_len[0] = region_sz;
			end
		endcase
		big = '0;
		cnt = 0;
		for (int i = 0; i < NUM_EXT; i++) begin
			if (!ext_used[i])
				continue;
			cnt++;
			if (ext_len[i] > big)
				big = ext_len[i];
		end
		r.largest_payload = (big > {24'd0, hdr_sz}) ? big - {24'd0, hdr_sz} : '0;
		r.extent_count = 7'(cnt);
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t r, e;
		logic [2:0] diff;
		if (!arst_n) begin
			region_sz <= REGION_RESET;
			hdr_sz <= HEADER_RESET;
			for (int i = 0; i < NUM_EXT; i++)
				ext_used[i] = 1'b0;
			exp_wr = '0;
			exp_rd = '0;
			pending <= 0;
			fail_count <= 0;
			nofit_seen <= 0;
			full_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_REGION)
					region_sz <= cfg_data;
				else
					hdr_sz <= cfg_data[7:0];
			end
			if (s_tvalid && s_tready) begin
				predict_command(kind_t'(s_tuser), s_tdata[31:0], s_tdata[63:32], r);
				expected_results[exp_wr] = r;
				exp_wr = exp_wr + 3'd1;
				if (r.status == ST_NOFIT)
					nofit_seen <= nofit_seen + 1;
				if (r.status == ST_FULL)
					full_seen <= full_seen + 1;
			end
			if (m_tvalid && m_tready) begin
				if (exp_wr == exp_rd) begin
					$error("result transaction with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_results[exp_rd];
					exp_rd = exp_rd + 3'd1;
					if (m_tdata[1:0] !== e.status ||
							m_tdata[33:2] !== e.alloc_offset ||
							m_tdata[65:34] !== e.largest_payload ||
							m_tdata[72:66] !== e.extent_count) begin
						fail_count <= fail_count + 1;
						if (m_tdata[1:0] !== e.status)
							$error("status: expected %0d, got %0d", e.status, m_tdata[1:0]);
						if (m_tdata[33:2] !== e.alloc_offset)
							$error("alloc_offset: expected %h, got %h",
								e.alloc_offset, m_tdata[33:2]);
						if (m_tdata[65:34] !== e.largest_payload)
							$error("largest_payload: expected %h, got %h",
								e.largest_payload, m_tdata[65:34]);
						if (m_tdata[72:66] !== e.extent_count)
							$error("extent_count: expected %0d, got %0d",
								e.extent_count, m_tdata[72:66]);
					end
				end
			end
			diff = exp_wr - exp_rd;
			pending <= int'(diff);
		end
	end

endmodule

@@ tb/sv/tb_best_fit_extent_allocator_core.sv @@
module tb_best_fit_extent_allocator_core;
	import bfea_pkg::*;

	localparam int DRAIN_CYCLES = 160;
	localparam int STALL_LIMIT = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_REGION;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = KIND_CLEAR;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;

	int fail_count, pending, nofit_seen, full_seen;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int idle_cycles = 0;
	int cmds_sent = 0;
	int kind_count [4] = '{0, 0, 0, 0};

	always #5 clk = ~clk;

	best_fit_extent_allocator_core dut (.*);

	bfea_checker chk (.*);

	always @(posedge clk) begin
		int hold_left;
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !arst_n ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("[best_fit_extent_allocator_core] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_cmd(input kind_t k, input logic [31:0] off, input logic [31:0] bytes);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {bytes, off};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		cmds_sent++;
		kind_count[k]++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// seed_pct biases toward filling the table
	task automatic random_cmds(input int count, input int seed_pct);
		kind_t k;
		logic [31:0] off, bytes;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 4)
				k = KIND_CLEAR;
			else if (r < 4 + seed_pct)
				k = KIND_SEED;
			else if (r < 4 + seed_pct + (96 - seed_pct) / 2)
				k = KIND_ALLOC;
			else
				k = KIND_RELEASE;
			off = ($urandom_range(99) < 75) ? 32'($urandom_range(127) * 16) : $urandom;
			if (seed_pct > 50 && $urandom_range(1))
				off = $urandom;
			bytes = ($urandom_range(99) < 80) ? 32'($urandom_range(40) * 8) : $urandom;
			if ($urandom_range(99) < 5)
				bytes = 32'hFFFF_FFFF - 32'($urandom_range(300));
			send_cmd(k, off, bytes);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_REGION, 32'd4096);
		write_reg(CFG_HEADER, 32'd8);
		send_cmd(KIND_ALLOC, 0, 16);
		send_cmd(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(KIND_ALLOC, 0, 32'hFFFF_FFFF);
		send_cmd(KIND_ALLOC, 0, 32'hFFFF_FFF8);
		send_cmd(KIND_ALLOC, 0, 0);
		send_cmd(KIND_ALLOC, 0, 56);
		send_cmd(KIND_ALLOC, 0, 24);
		send_cmd(KIND_RELEASE, 8, 56);
		send_cmd(KIND_RELEASE, 0, 0);
		send_cmd(KIND_RELEASE, 72, 24);
		send_cmd(KIND_RELEASE, 2048, 100);
		send_cmd(KIND_RELEASE, 2048, 40);
		send_cmd(KIND_RELEASE, 2000, 40);
		send_cmd(KIND_SEED, 2048, 7);
		send_cmd(KIND_SEED, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_cmd(KIND_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(KIND_ALLOC, 0, 32'hFFFF_FF00);
		send_cmd(KIND_ALLOC, 0, 4000);
		send_cmd(KIND_SEED, 100, 0);
		send_cmd(KIND_ALLOC, 0, 0);
		send_cmd(KIND_CLEAR, 0, 0);
		settle();

		write_reg(CFG_REGION, 32'd8);
		write_reg(CFG_HEADER, 32'd0);
		send_cmd(KIND_CLEAR, 0, 0);
		send_cmd(KIND_ALLOC, 0, 8);
		random_cmds(120, 16);
		settle();

		write_reg(CFG_REGION, 32'hFFFF_FFFF);
		write_reg(CFG_HEADER, 32'd255);
		send_idle_pct = 74;
		random_cmds(100, 16);
		settle();

		write_reg(CFG_REGION, 32'd2048);
		write_reg(CFG_HEADER, 32'd16);
		send_idle_pct = 0;
		recv_stall_pct = 74;
		random_cmds(110, 70);
		settle();

		write_reg(CFG_REGION, 32'd3000);
		write_reg(CFG_HEADER, 32'd8);
		send_idle_pct = 37;
		recv_stall_pct = 37;
		random_cmds(110, 16);
		settle();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 800;
		random_cmds(130, 20);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d commands (alloc %0d, release %0d, seed %0d, clear %0d)",
			cmds_sent, kind_count[KIND_ALLOC], kind_count[KIND_RELEASE],
			kind_count[KIND_SEED], kind_count[KIND_CLEAR]);
		$display("no-fit answers %0d, table-full answers %0d, mismatches %0d",
			nofit_seen, full_seen, fail_count);
		if (fail_count == 0)
			$display("[best_fit_extent_allocator_core] OK");
		else
			$display("[best_fit_extent_allocator_core] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
src/bfea_pkg.sv
src/best_fit_extent_allocator_core.sv
tb/sv/bfea_checker.sv
tb/sv/tb_best_fit_extent_allocator_core.sv
